// File: sv/bwl_pkg.sv
// ----------------------------------------------------------------------------
// bwl_pkg
// Types and constants shared by the weight layout reorder block.
// ----------------------------------------------------------------------------
package bwl_pkg;

    localparam int WORD_W       = 32;
    localparam int IDX_W        = 30;
    localparam int TOTAL_W      = IDX_W + 1;
    localparam int SPAT_W       = 5;
    localparam int CHAN_W       = 12;
    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int IO_W         = 23;
    localparam int HW_W         = 9;
    localparam int WIO_W        = 28;
    localparam int MAX_SPATIAL  = 16;
    localparam int MAX_CHANNELS = 2048;
    localparam int BLOCK_SHIFT  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 2'd3;

    typedef enum logic [1:0] {
        MODE_BLOCK_IO = 2'd0,
        MODE_BLOCK_O  = 2'd1,
        MODE_PASS     = 2'd2
    } layout_mode_t;

    // geometry handed from the configuration unit to the position unit
    typedef struct packed {
        logic [SPAT_W-1:0]  kh;
        logic [SPAT_W-1:0]  kw;
        logic [CHAN_W-1:0]  ic;
        logic [CHAN_W-1:0]  oc;
        logic [IO_W-1:0]    io_stride;
        logic [WIO_W-1:0]   wio_stride;
        logic [TOTAL_W-1:0] total;
        layout_mode_t       mode;
        logic               clear;
        logic               settled;
    } geom_t;

    typedef struct packed {
        logic [IDX_W-1:0]  dest;
        logic [WORD_W-1:0] word;
        layout_mode_t      mode;
        logic              last;
    } result_t;

endpackage

// File: sv/blocked_weight_layout_to_hwio.sv
// ----------------------------------------------------------------------------
// blocked_weight_layout_to_hwio
// Reorders blocked convolution weights into height-width-input-output order.
// ----------------------------------------------------------------------------
// One weight beat is accepted per clock while tready is high and yields one
// result beat carrying the word, its destination index, the source layout and
// a last flag on the final element of the tensor. The index comes from nested
// position counters and stride accumulators in a single registered pass, so
// throughput is one beat per cycle while tready is high; a two-entry result
// buffer keeps the slave side open while a result waits. After reset and after
// every register write, tready stays low while the channel and spatial stride
// products settle in their two multiplier stages. Any write restarts the tensor.
module blocked_weight_layout_to_hwio (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bwl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bwl_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // weight_word[31:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // dest_index[29:0], word_out[61:30]
    output logic [1:0]                    m_tuser,  // layout_mode[1:0]
    output logic                          m_tlast
);
    import bwl_pkg::*;

    geom_t            geom;
    logic             accept;
    logic             has_room;
    logic [IDX_W-1:0] dest;
    logic             last;
    result_t          res_in;
    result_t          res_out;

    assign s_tready = geom.settled && has_room;
    assign accept   = s_tvalid && s_tready;

    bwl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    bwl_pos u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .advance (accept),
        .dest    (dest),
        .last    (last)
    );

    always_comb
    begin
        res_in.dest = dest;
        res_in.word = s_tdata;
        res_in.mode = geom.mode;
        res_in.last = last;
    end

    bwl_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res_in),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {2'b00, res_out.word, res_out.dest};
    assign m_tuser = res_out.mode;
    assign m_tlast = res_out.last;

endmodule

// File: sv/bwl_cfg.sv
// ----------------------------------------------------------------------------
// bwl_cfg
// Dimension registers, clamping, layout selection and stride products.
// ----------------------------------------------------------------------------
module bwl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bwl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bwl_pkg::CFG_W-1:0]     cfg_data,
    output bwl_pkg::geom_t                geom
);
    import bwl_pkg::*;

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    logic [SPAT_W-1:0] kh_reg;
    logic [SPAT_W-1:0] kw_reg;
    logic [CHAN_W-1:0] ic_reg;
    logic [CHAN_W-1:0] oc_reg;
    logic [1:0]        settle_reg;
    logic [1:0]        settle_next;

    logic [SPAT_W-1:0] kh_c;
    logic [SPAT_W-1:0] kw_c;
    logic [CHAN_W-1:0] ic_c;
    logic [CHAN_W-1:0] oc_c;

    logic [2*CHAN_W-1:0]      io_prod;
    logic [2*SPAT_W-1:0]      hw_prod;
    logic [IO_W-1:0]          io_reg;
    logic [HW_W-1:0]          hw_reg;
    logic [SPAT_W+IO_W-1:0]   wio_prod;
    logic [HW_W+IO_W-1:0]     total_prod;
    logic [WIO_W-1:0]         wio_reg;
    logic [TOTAL_W-1:0]       total_reg;
    layout_mode_t             mode_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kh_reg     <= SPAT_W'(1);
            kw_reg     <= SPAT_W'(1);
            ic_reg     <= CHAN_W'(8);
            oc_reg     <= CHAN_W'(8);
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_KERNEL_HEIGHT: kh_reg <= cfg_data[SPAT_W-1:0];
                    REG_KERNEL_WIDTH:  kw_reg <= cfg_data[SPAT_W-1:0];
                    REG_IN_CHANNELS:   ic_reg <= cfg_data;
                    REG_OUT_CHANNELS:  oc_reg <= cfg_data;
                    default:           kh_reg <= kh_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cfg_wr_en)
            settle_next = SETTLE_CYCLES;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    // zero reads as one, anything above the maximum reads as the maximum
    always_comb
    begin
        kh_c = (kh_reg == '0) ? SPAT_W'(1)
             : (kh_reg > SPAT_W'(MAX_SPATIAL)) ? SPAT_W'(MAX_SPATIAL) : kh_reg;
        kw_c = (kw_reg == '0) ? SPAT_W'(1)
             : (kw_reg > SPAT_W'(MAX_SPATIAL)) ? SPAT_W'(MAX_SPATIAL) : kw_reg;
        ic_c = (ic_reg == '0) ? CHAN_W'(1)
             : (ic_reg > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : ic_reg;
        oc_c = (oc_reg == '0) ? CHAN_W'(1)
             : (oc_reg > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : oc_reg;
    end

    always_comb
    begin
        if (oc_c[BLOCK_SHIFT-1:0] == '0 && ic_c[BLOCK_SHIFT-1:0] == '0)
            mode_c = MODE_BLOCK_IO;
        else if (oc_c[BLOCK_SHIFT-1:0] == '0)
            mode_c = MODE_BLOCK_O;
        else
            mode_c = MODE_PASS;
    end

    // two product stages, ready once both have settled
    assign io_prod    = ic_c * oc_c;
    assign hw_prod    = kh_c * kw_c;
    assign wio_prod   = kw_c * io_reg;
    assign total_prod = hw_reg * io_reg;

    always_ff @(posedge clk)
    begin
        io_reg    <= io_prod[IO_W-1:0];
        hw_reg    <= hw_prod[HW_W-1:0];
        wio_reg   <= wio_prod[WIO_W-1:0];
        total_reg <= total_prod[TOTAL_W-1:0];
    end

    always_comb
    begin
        geom.kh         = kh_c;
        geom.kw         = kw_c;
        geom.ic         = ic_c;
        geom.oc         = oc_c;
        geom.io_stride  = io_reg;
        geom.wio_stride = wio_reg;
        geom.total      = total_reg;
        geom.mode       = mode_c;
        geom.clear      = cfg_wr_en && (cfg_index == REG_KERNEL_HEIGHT
                                     || cfg_index == REG_KERNEL_WIDTH
                                     || cfg_index == REG_IN_CHANNELS
                                     || cfg_index == REG_OUT_CHANNELS);
        geom.settled    = (settle_reg == 2'd0);
    end

endmodule

// File: sv/bwl_pos.sv
// ----------------------------------------------------------------------------
// bwl_pos
// Nested position counters with stride accumulators; forms the destination
// index and the last flag of the current beat.
// ----------------------------------------------------------------------------
module bwl_pos (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bwl_pkg::geom_t            geom,
    input  logic                      advance,
    output logic [bwl_pkg::IDX_W-1:0] dest,
    output logic                      last
);
    import bwl_pkg::*;

    logic [2:0]        o8_reg, o8_next;
    logic [2:0]        i8_reg, i8_next;
    logic [3:0]        w_reg, w_next;
    logic [3:0]        h_reg, h_next;
    logic [10:0]       ib_reg, ib_next;
    logic [7:0]        ob_reg, ob_next;
    logic [IDX_W-1:0]  lin_reg, lin_next;
    logic [IDX_W-1:0]  spat_reg, spat_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  chan_reg, chan_next;
    logic [IDX_W-1:0]  ibo_reg, ibo_next;

    logic [IDX_W-1:0]  o_str;
    logic [IDX_W-1:0]  o8_str;
    logic [IDX_W-1:0]  io_str;
    logic [IDX_W-1:0]  wio_str;
    logic [CHAN_W-1:0] ib_lim;
    logic              wrap_o8, wrap_i8, wrap_w, wrap_h, wrap_ib, wrap_ob;
    logic              t_w, t_h, t_ib, t_ob;
    logic [10:0]       oc_idx;

    assign o_str   = IDX_W'(geom.oc);
    assign o8_str  = IDX_W'({geom.oc, 3'b000});
    assign io_str  = IDX_W'(geom.io_stride);
    assign wio_str = IDX_W'(geom.wio_stride);
    assign ib_lim  = (geom.mode == MODE_BLOCK_IO) ?
                     CHAN_W'(geom.ic[CHAN_W-1:BLOCK_SHIFT]) : geom.ic;

    assign wrap_o8 = (o8_reg == 3'd7);
    assign wrap_i8 = (i8_reg == 3'd7);
    assign wrap_w  = ({1'b0, w_reg} + SPAT_W'(1)) >= geom.kw;
    assign wrap_h  = ({1'b0, h_reg} + SPAT_W'(1)) >= geom.kh;
    assign wrap_ib = ({1'b0, ib_reg} + CHAN_W'(1)) >= ib_lim;
    assign wrap_ob = ({1'b0, ob_reg} + 9'd1) >= geom.oc[CHAN_W-1:BLOCK_SHIFT];

    assign oc_idx = {ob_reg, o8_reg};
    assign dest   = (geom.mode == MODE_PASS) ? lin_reg
                  : spat_reg + chan_reg + IDX_W'(oc_idx);
    assign last   = ({1'b0, lin_reg} + TOTAL_W'(1)) >= geom.total;

    always_comb
    begin
        o8_next   = o8_reg;
        i8_next   = i8_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        ib_next   = ib_reg;
        ob_next   = ob_reg;
        lin_next  = lin_reg;
        spat_next = spat_reg;
        row_next  = row_reg;
        chan_next = chan_reg;
        ibo_next  = ibo_reg;
        t_w       = 1'b0;
        t_h       = 1'b0;
        t_ib      = 1'b0;
        t_ob      = 1'b0;

        if (geom.clear || (advance && last))
        begin
            o8_next   = '0;
            i8_next   = '0;
            w_next    = '0;
            h_next    = '0;
            ib_next   = '0;
            ob_next   = '0;
            lin_next  = '0;
            spat_next = '0;
            row_next  = '0;
            chan_next = '0;
            ibo_next  = '0;
        end
        else if (advance)
        begin
            lin_next = lin_reg + IDX_W'(1);
            case (geom.mode)
                MODE_BLOCK_IO:
                begin
                    o8_next = wrap_o8 ? 3'd0 : o8_reg + 3'd1;
                    t_w  = wrap_o8 && wrap_i8;
                    t_h  = t_w && wrap_w;
                    t_ib = t_h && wrap_h;
                    t_ob = t_ib && wrap_ib;
                    if (wrap_o8)
                        i8_next = wrap_i8 ? 3'd0 : i8_reg + 3'd1;
                    if (t_ib)
                    begin
                        ib_next  = wrap_ib ? 11'd0 : ib_reg + 11'd1;
                        ibo_next = wrap_ib ? '0 : ibo_reg + o8_str;
                    end
                    // the sub-block channel offset restarts from the block base
                    if (wrap_o8)
                        chan_next = wrap_i8 ? ibo_next : chan_reg + o_str;
                end
                MODE_BLOCK_O:
                begin
                    o8_next = wrap_o8 ? 3'd0 : o8_reg + 3'd1;
                    t_ib = wrap_o8;
                    t_w  = t_ib && wrap_ib;
                    t_h  = t_w && wrap_w;
                    t_ob = t_h && wrap_h;
                    if (t_ib)
                    begin
                        ib_next   = wrap_ib ? 11'd0 : ib_reg + 11'd1;
                        chan_next = wrap_ib ? '0 : chan_reg + o_str;
                    end
                end
                default:
                begin
                    t_w = 1'b0;
                end
            endcase

            if (t_w)
                w_next = wrap_w ? 4'd0 : w_reg + 4'd1;
            if (t_h)
            begin
                h_next   = wrap_h ? 4'd0 : h_reg + 4'd1;
                row_next = wrap_h ? '0 : row_reg + wio_str;
            end
            if (t_w)
                spat_next = wrap_w ? row_next : spat_reg + io_str;
            if (t_ob)
                ob_next = wrap_ob ? 8'd0 : ob_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o8_reg   <= '0;
            i8_reg   <= '0;
            w_reg    <= '0;
            h_reg    <= '0;
            ib_reg   <= '0;
            ob_reg   <= '0;
            lin_reg  <= '0;
            spat_reg <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
            ibo_reg  <= '0;
        end
        else
        begin
            o8_reg   <= o8_next;
            i8_reg   <= i8_next;
            w_reg    <= w_next;
            h_reg    <= h_next;
            ib_reg   <= ib_next;
            ob_reg   <= ob_next;
            lin_reg  <= lin_next;
            spat_reg <= spat_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
            ibo_reg  <= ibo_next;
        end
    end

endmodule

// File: sv/bwl_obuf.sv
// ----------------------------------------------------------------------------
// bwl_obuf
// Result register with a skid stage, so a new beat is taken while a result
// waits on the master side.
// ----------------------------------------------------------------------------
module bwl_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bwl_pkg::result_t push_data,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output bwl_pkg::result_t out_data
);
    import bwl_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign has_room  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= push_data;
            else
                out_reg <= push_data;
        end
    end

endmodule

// File: sv/bwl_checker.sv
// ----------------------------------------------------------------------------
// bwl_checker
// Port-level checks for the weight layout reorder block, bound to the top.
// ----------------------------------------------------------------------------
module bwl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds its beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // strides are recomputed after a write, so no beat is taken next cycle
    a_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready)
        else $error("beat accepted before strides settled");

    // with an empty result side and settled strides the slave side is open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(cfg_wr_en) && !$past(cfg_wr_en, 2)
        && $past(rst_n) && $past(rst_n, 2) |-> s_tready)
        else $error("slave side closed while idle");

    // a result only appears after a beat was taken
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result beat without an input beat");

endmodule

bind blocked_weight_layout_to_hwio bwl_checker u_bwl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);
